FILE: rtl/bfiq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Bloom filter package
// Field widths, register indexes, operation codes, hash constants and the
// types shared by the Bloom filter modules.
// ----------------------------------------------------------------------------
package bfiq_pkg;

  // Default structural sizes
  localparam int unsigned DEF_FILTER_BITS = 65536;
  localparam int unsigned DEF_KEY_BYTES   = 8;
  localparam int unsigned DEF_MAX_HASHES  = 64;

  // Field widths
  localparam int unsigned KIND_W     = 2;
  localparam int unsigned KEY_W      = 64;
  localparam int unsigned LEN_W      = 4;
  localparam int unsigned SIZE_W     = 17;
  localparam int unsigned HCNT_W     = 7;
  localparam int unsigned CNT_W      = 32;
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 17;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_SIZE = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HASH_COUNT  = 4'd1;

  // Register reset values
  localparam logic [SIZE_W-1:0] RST_FILTER_SIZE = 17'd65536;
  localparam logic [HCNT_W-1:0] RST_HASH_COUNT  = 7'd7;

  // Operation codes
  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

  // Hash round constants
  localparam logic [KEY_W-1:0] GOLD    = 64'h9e37_79b9_7f4a_7c15;
  localparam logic [31:0]      GOLD_LO = GOLD[31:0];
  localparam logic [31:0]      GOLD_HI = GOLD[63:32];
  localparam int unsigned      XSHIFT  = 47;

  // Bit store row layout
  localparam int unsigned ROW_BITS  = 32;
  localparam int unsigned ROW_SEL_W = $clog2(ROW_BITS);

  // Modulo pipeline: hash bits consumed per stage
  localparam int unsigned MOD_STEP   = 4;
  localparam int unsigned MOD_STAGES = KEY_W / MOD_STEP;

  // Per-seed tag that travels with each hash through the pipelines
  typedef struct packed {
    logic vld;
    logic last;
  } tag_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN,
    ST_REPLY
  } state_t;

endpackage
`default_nettype wire

FILE: rtl/bfiq_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module bfiq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 2048,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

FILE: rtl/bfiq_hash_pipe.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Bloom filter hash pipeline
// One round per key byte, two stages per round: XOR the byte and form the
// partial products of the golden-ratio multiply, then sum them and fold the
// high bits down. Rounds past the key length pass the hash through.
// ----------------------------------------------------------------------------
module bfiq_hash_pipe #(
  parameter int unsigned KEY_BYTES = bfiq_pkg::DEF_KEY_BYTES
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire bfiq_pkg::tag_t                in_tag,
  input  wire logic [bfiq_pkg::HCNT_W-1:0]   seed,
  input  wire logic [bfiq_pkg::KEY_W-1:0]    key,
  input  wire logic [bfiq_pkg::LEN_W-1:0]    key_len,
  output bfiq_pkg::tag_t                     out_tag,
  output logic      [bfiq_pkg::KEY_W-1:0]    hash
);

  logic [bfiq_pkg::KEY_W-1:0] rh [KEY_BYTES+1];
  bfiq_pkg::tag_t             rt [KEY_BYTES+1];

  assign rh[0] = bfiq_pkg::KEY_W'(seed);
  assign rt[0] = in_tag;

  for (genvar r = 0; r < KEY_BYTES; r++) begin : g_round
    logic [bfiq_pkg::KEY_W-1:0] x;
    logic [bfiq_pkg::KEY_W-1:0] m0;
    logic [31:0]                m1;
    logic [31:0]                m2;
    logic [bfiq_pkg::KEY_W-1:0] p;
    logic [bfiq_pkg::KEY_W-1:0] pp0_r;
    logic [31:0]                pp1_r;
    logic [31:0]                pp2_r;
    logic [bfiq_pkg::KEY_W-1:0] h_r;
    logic [bfiq_pkg::KEY_W-1:0] hb_r;
    logic                       act_r;
    bfiq_pkg::tag_t             ta_r;
    bfiq_pkg::tag_t             tb_r;

    // XOR in the key byte and split the 64x64 low product into 32x32 parts
    assign x  = rh[r] ^ bfiq_pkg::KEY_W'(key[8*r +: 8]);
    assign m0 = x[31:0] * bfiq_pkg::GOLD_LO;
    assign m1 = x[31:0] * bfiq_pkg::GOLD_HI;
    assign m2 = x[63:32] * bfiq_pkg::GOLD_LO;

    // Sum partial products modulo 2^64
    assign p = pp0_r + {32'(pp1_r + pp2_r), 32'b0};

    // Advance tags
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ta_r <= '0;
        tb_r <= '0;
      end else begin
        ta_r <= rt[r];
        tb_r <= ta_r;
      end
    end

    // Round datapath
    always_ff @(posedge clk) begin
      pp0_r <= m0;
      pp1_r <= m1;
      pp2_r <= m2;
      h_r   <= rh[r];
      act_r <= (bfiq_pkg::LEN_W'(r) < key_len);
      hb_r  <= act_r ? (p ^ (p >> bfiq_pkg::XSHIFT)) : h_r;
    end

    assign rh[r+1] = hb_r;
    assign rt[r+1] = tb_r;
  end

  assign out_tag = rt[KEY_BYTES];
  assign hash    = rh[KEY_BYTES];

endmodule
`default_nettype wire

FILE: rtl/bfiq_mod_pipe.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Bloom filter modulo pipeline
// Restoring remainder of a 64-bit hash by the filter size, a few hash bits
// per stage, one compare and subtract per bit.
// ----------------------------------------------------------------------------
module bfiq_mod_pipe (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire bfiq_pkg::tag_t                in_tag,
  input  wire logic [bfiq_pkg::KEY_W-1:0]    hash,
  input  wire logic [bfiq_pkg::SIZE_W-1:0]   size,
  output bfiq_pkg::tag_t                     out_tag,
  output logic      [bfiq_pkg::SIZE_W-1:0]   rem
);

  localparam int unsigned STAGES = bfiq_pkg::MOD_STAGES;
  localparam int unsigned SW     = bfiq_pkg::SIZE_W;

  bfiq_pkg::tag_t             st [STAGES+1];
  logic [bfiq_pkg::KEY_W-1:0] sh [STAGES+1];
  logic [SW-1:0]              sr [STAGES+1];

  assign st[0] = in_tag;
  assign sh[0] = hash;
  assign sr[0] = '0;

  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    logic [SW-1:0]              rnext;
    logic [SW-1:0]              r_r;
    logic [bfiq_pkg::KEY_W-1:0] h_r;
    bfiq_pkg::tag_t             t_r;

    // Shift in hash bits, subtract the size whenever the partial rem reaches it
    always_comb begin : step
      logic [SW:0] acc;
      acc   = '0;
      rnext = sr[s];
      for (int j = 0; j < bfiq_pkg::MOD_STEP; j++) begin
        acc = {rnext, sh[s][bfiq_pkg::KEY_W - 1 - bfiq_pkg::MOD_STEP * s - j]};
        if (acc >= {1'b0, size}) begin
          acc = acc - {1'b0, size};
        end
        rnext = acc[SW-1:0];
      end
    end

    // Advance tag
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        t_r <= '0;
      end else begin
        t_r <= st[s];
      end
    end

    // Hold hash and partial remainder
    always_ff @(posedge clk) begin
      h_r <= sh[s];
      r_r <= rnext;
    end

    assign st[s+1] = t_r;
    assign sh[s+1] = h_r;
    assign sr[s+1] = r_r;
  end

  assign out_tag = st[STAGES];
  assign rem     = sr[STAGES];

endmodule
`default_nettype wire

FILE: rtl/bloom_filter_insert_query_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Bloom filter with insert, query and clear
// The bit store sits in one RAM of 32-bit rows. After reset, and for every
// clear, the block sweeps the RAM one row a cycle with in_ready low; a clear
// beat is answered when its sweep ends. An insert or query issues one seed a
// cycle into the hash pipeline (two stages per key byte) and the 16-stage
// modulo pipeline, and each resulting index does one read and, for an
// insert, one write-back on the RAM, with forwarding of the last row
// written. The result of an insert or query is loaded into the output
// register once the last seed has passed the RAM stage and the output is
// free, and the block then returns to idle to take the next beat. Other
// kinds go straight to the reply state and are answered the same way. One
// item is in work at a time; a new beat is taken while the previous result
// waits at the output.
// Configuration writes are always accepted.
// ----------------------------------------------------------------------------
module bloom_filter_insert_query_top #(
  parameter int unsigned FILTER_BITS = bfiq_pkg::DEF_FILTER_BITS,
  parameter int unsigned KEY_BYTES   = bfiq_pkg::DEF_KEY_BYTES,
  parameter int unsigned MAX_HASHES  = bfiq_pkg::DEF_MAX_HASHES
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [bfiq_pkg::KIND_W-1:0]       in_kind,
  input  wire logic [bfiq_pkg::KEY_W-1:0]        in_key,
  input  wire logic [bfiq_pkg::LEN_W-1:0]        in_key_len,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic                                   out_maybe_present,
  output logic      [bfiq_pkg::CNT_W-1:0]        out_insert_count,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [bfiq_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [bfiq_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int unsigned ROW_BITS = bfiq_pkg::ROW_BITS;
  localparam int unsigned SEL_W    = bfiq_pkg::ROW_SEL_W;
  localparam int unsigned ROWS     = (FILTER_BITS + ROW_BITS - 1) / ROW_BITS;
  localparam int unsigned ADDR_W   = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned SIZE_W   = bfiq_pkg::SIZE_W;
  localparam int unsigned HCNT_W   = bfiq_pkg::HCNT_W;
  localparam int unsigned CNT_W    = bfiq_pkg::CNT_W;

  // Controller
  bfiq_pkg::state_t state_r, state_nxt;
  logic             in_acc;
  logic             issue;
  logic             clearing;
  logic             reply_load;
  logic             clr_last;
  logic             seed_last;

  // Configuration
  logic [SIZE_W-1:0] filter_size_r;
  logic [HCNT_W-1:0] hash_count_r;
  logic [SIZE_W-1:0] size_use;
  logic [HCNT_W-1:0] hcnt_use;

  // Item context
  logic [bfiq_pkg::KIND_W-1:0] kind_r;
  logic [bfiq_pkg::KEY_W-1:0]  key_r;
  logic [bfiq_pkg::LEN_W-1:0]  len_r;
  logic [SIZE_W-1:0]           size_r;
  logic [HCNT_W-1:0]           hcnt_r;
  logic [HCNT_W-1:0]           seed_r;
  logic                        present_r;
  logic                        reply_pend_r;
  logic [CNT_W-1:0]            count_r;
  logic [CNT_W-1:0]            count_nxt;
  logic [ADDR_W-1:0]           clr_cnt_r;

  // Pipelines
  bfiq_pkg::tag_t             hash_in_tag;
  bfiq_pkg::tag_t             hash_tag;
  logic [bfiq_pkg::KEY_W-1:0] hash_val;
  bfiq_pkg::tag_t             mod_tag;
  logic [SIZE_W-1:0]          mod_rem;

  // Memory access
  logic [ADDR_W-1:0]   rd_addr;
  logic [ROW_BITS-1:0] rd_data;
  bfiq_pkg::tag_t      m_tag_r;
  logic [ADDR_W-1:0]   m_addr_r;
  logic [SEL_W-1:0]    m_sel_r;
  logic [ROW_BITS-1:0] row;
  logic                wr_en;
  logic [ADDR_W-1:0]   wr_addr;
  logic [ROW_BITS-1:0] wr_data;
  logic                lw_vld_r;
  logic [ADDR_W-1:0]   lw_addr_r;
  logic [ROW_BITS-1:0] lw_data_r;

  // Output register
  logic             out_valid_r;
  logic             out_present_r;
  logic [CNT_W-1:0] out_count_r;

  // Configuration writes
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filter_size_r <= bfiq_pkg::RST_FILTER_SIZE;
      hash_count_r  <= bfiq_pkg::RST_HASH_COUNT;
    end else if (cfg_valid) begin
      case (cfg_index)
        bfiq_pkg::REG_FILTER_SIZE: filter_size_r <= cfg_data[SIZE_W-1:0];
        bfiq_pkg::REG_HASH_COUNT:  hash_count_r  <= cfg_data[HCNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp size and hash count to their usable ranges
  always_comb begin
    size_use = filter_size_r;
    if (filter_size_r == '0) begin
      size_use = SIZE_W'(1);
    end else if (32'(filter_size_r) > FILTER_BITS) begin
      size_use = SIZE_W'(FILTER_BITS);
    end
    hcnt_use = hash_count_r;
    if (hash_count_r == '0) begin
      hcnt_use = HCNT_W'(1);
    end else if (32'(hash_count_r) > MAX_HASHES) begin
      hcnt_use = HCNT_W'(MAX_HASHES);
    end
  end

  assign in_acc    = in_valid && in_ready;
  assign clr_last  = (clr_cnt_r == ADDR_W'(ROWS - 1));
  assign seed_last = (seed_r == hcnt_r - HCNT_W'(1));

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bfiq_pkg::ST_CLEAR: begin
        if (clr_last) begin
          state_nxt = reply_pend_r ? bfiq_pkg::ST_REPLY : bfiq_pkg::ST_IDLE;
        end
      end
      bfiq_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (in_kind inside {bfiq_pkg::KIND_INSERT, bfiq_pkg::KIND_QUERY}) begin
            state_nxt = bfiq_pkg::ST_ISSUE;
          end else if (in_kind == bfiq_pkg::KIND_CLEAR) begin
            state_nxt = bfiq_pkg::ST_CLEAR;
          end else begin
            state_nxt = bfiq_pkg::ST_REPLY;
          end
        end
      end
      bfiq_pkg::ST_ISSUE: begin
        if (seed_last) begin
          state_nxt = bfiq_pkg::ST_DRAIN;
        end
      end
      bfiq_pkg::ST_DRAIN: begin
        if (m_tag_r.vld && m_tag_r.last) begin
          state_nxt = bfiq_pkg::ST_REPLY;
        end
      end
      bfiq_pkg::ST_REPLY: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = bfiq_pkg::ST_IDLE;
        end
      end
      default: state_nxt = bfiq_pkg::ST_CLEAR;
    endcase
  end

  // Controller outputs
  always_comb begin
    in_ready   = (state_r == bfiq_pkg::ST_IDLE);
    issue      = (state_r == bfiq_pkg::ST_ISSUE);
    clearing   = (state_r == bfiq_pkg::ST_CLEAR);
    reply_load = (state_r == bfiq_pkg::ST_REPLY) && (!out_valid_r || out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bfiq_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Latch the item context on accept
  always_ff @(posedge clk) begin
    if (in_acc) begin
      kind_r <= in_kind;
      key_r  <= in_key;
      len_r  <= in_key_len;
      size_r <= size_use;
      hcnt_r <= hcnt_use;
    end
  end

  // Seed counter, clear sweep counter, pending clear reply
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r       <= '0;
      clr_cnt_r    <= '0;
      reply_pend_r <= 1'b0;
    end else begin
      if (in_acc) begin
        seed_r       <= '0;
        reply_pend_r <= (in_kind == bfiq_pkg::KIND_CLEAR);
      end else if (issue) begin
        seed_r <= seed_r + HCNT_W'(1);
      end
      if (clearing) begin
        clr_cnt_r <= clr_last ? '0 : clr_cnt_r + ADDR_W'(1);
      end
    end
  end

  // Insert counter, saturating
  assign count_nxt = (kind_r == bfiq_pkg::KIND_INSERT && count_r != '1) ?
                     count_r + CNT_W'(1) : count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (in_acc && in_kind == bfiq_pkg::KIND_CLEAR) begin
      count_r <= '0;
    end else if (reply_load) begin
      count_r <= count_nxt;
    end
  end

  // Hash and modulo pipelines
  assign hash_in_tag.vld  = issue;
  assign hash_in_tag.last = seed_last;

  bfiq_hash_pipe #(
    .KEY_BYTES (KEY_BYTES)
  ) u_hash (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_tag  (hash_in_tag),
    .seed    (seed_r),
    .key     (key_r),
    .key_len (len_r),
    .out_tag (hash_tag),
    .hash    (hash_val)
  );

  bfiq_mod_pipe u_mod (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_tag  (hash_tag),
    .hash    (hash_val),
    .size    (size_r),
    .out_tag (mod_tag),
    .rem     (mod_rem)
  );

  // Read the row holding the indexed bit
  assign rd_addr = ADDR_W'(mod_rem >> SEL_W);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_tag_r <= '0;
    end else begin
      m_tag_r <= mod_tag;
    end
  end

  always_ff @(posedge clk) begin
    m_addr_r <= rd_addr;
    m_sel_r  <= mod_rem[SEL_W-1:0];
  end

  // Forward the row written last cycle over the stale read
  assign row = (lw_vld_r && lw_addr_r == m_addr_r) ? lw_data_r : rd_data;

  // Write back: zero rows while sweeping, set the bit on insert
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = m_addr_r;
    wr_data = row | (ROW_BITS'(1) << m_sel_r);
    if (clearing) begin
      wr_en   = 1'b1;
      wr_addr = clr_cnt_r;
      wr_data = '0;
    end else if (m_tag_r.vld && kind_r == bfiq_pkg::KIND_INSERT) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lw_vld_r <= 1'b0;
    end else begin
      lw_vld_r <= wr_en;
    end
  end

  always_ff @(posedge clk) begin
    lw_addr_r <= wr_addr;
    lw_data_r <= wr_data;
  end

  bfiq_ram #(
    .WIDTH (ROW_BITS),
    .DEPTH (ROWS)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (mod_tag.vld),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Drop the present flag on any clear bit of a query
  always_ff @(posedge clk) begin
    if (in_acc) begin
      present_r <= 1'b1;
    end else if (m_tag_r.vld && kind_r == bfiq_pkg::KIND_QUERY && !row[m_sel_r]) begin
      present_r <= 1'b0;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (reply_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (reply_load) begin
      out_present_r <= (kind_r == bfiq_pkg::KIND_QUERY) && present_r;
      out_count_r   <= count_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_maybe_present = out_present_r;
  assign out_insert_count  = out_count_r;

  // Assertions
  a_no_lookup_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bfiq_pkg::ST_CLEAR) |-> !mod_tag.vld)
    else $error("store lookup issued during clear sweep");

  a_mem_stage_in_item: assert property (@(posedge clk) disable iff (!rst_n)
    m_tag_r.vld |-> (state_r == bfiq_pkg::ST_ISSUE || state_r == bfiq_pkg::ST_DRAIN))
    else $error("store access outside an insert or query");

  a_count_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_acc && in_kind == bfiq_pkg::KIND_CLEAR) |=> (count_r >= $past(count_r)))
    else $error("insert counter dropped without a clear");

endmodule
`default_nettype wire
